>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the async PPP frame encoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define PAFE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pafe: assertion failed");
// Condition must never be seen outside reset
`define PAFE_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("pafe: forbidden condition seen");
`else
`define PAFE_ASSERT(lbl, clk, rst_n, prop)
`define PAFE_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> hw/rtl/pafe_pkg.sv
// ----------------------------------------------------------------------------
// pafe_pkg
// Types, constants and the FCS-16 byte update for the async PPP encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pafe_pkg;

  // Line bytes
  localparam logic [7:0]  FLAG_BYTE    = 8'h7E;
  localparam logic [7:0]  ESC_BYTE     = 8'h7D;
  localparam logic [7:0]  XOR_BYTE     = 8'h20;
  localparam logic [7:0]  ADDR_BYTE    = 8'hFF;
  localparam logic [7:0]  CTRL_BYTE    = 8'h03;
  localparam logic [15:0] LCP_PROTOCOL = 16'hC021;

  // FCS-16, reflected
  localparam logic [15:0] FCS_INIT      = 16'hFFFF;
  localparam logic [15:0] FCS_POLY      = 16'h8408;
  localparam int          BITS_PER_BYTE = 8;

  // Symbol queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCM = 2'd0,
    CFG_ACF  = 2'd1,
    CFG_PF   = 2'd2
  } cfg_reg_t;

  // Symbol slots of one item, in line order
  localparam int SLOT_W   = 4;
  localparam int SLOT_CNT = 9;
  typedef enum logic [SLOT_W-1:0] {
    SLOT_OPEN  = 4'd0,
    SLOT_ADDR  = 4'd1,
    SLOT_CTRL  = 4'd2,
    SLOT_PHI   = 4'd3,
    SLOT_PLO   = 4'd4,
    SLOT_DATA  = 4'd5,
    SLOT_FLO   = 4'd6,
    SLOT_FHI   = 4'd7,
    SLOT_CLOSE = 4'd8
  } slot_t;

  // Back-end escape sequencer states
  typedef enum logic {
    BK_PASS = 1'b0,
    BK_ESC2 = 1'b1
  } back_state_t;

  // Input beat
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        has_data;
    logic        frame_start;
    logic        frame_end;
    logic [15:0] protocol;
  } enc_in_t;

  // Output beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       closing_flag;
  } enc_out_t;

  // Unescaped symbol handed from front to back
  typedef struct packed {
    logic [7:0] sym_byte;
    logic       esc;
    logic       closing;
    logic       last;
  } sym_t;

  // Fold one byte into the running FCS, one bit per step
  function automatic logic [15:0] fcs16_byte(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] f;
    f = fcs ^ {8'h00, b};
    for (int i = 0; i < BITS_PER_BYTE; i++) begin
      f = f[0] ? ((f >> 1) ^ FCS_POLY) : (f >> 1);
    end
    return f;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pafe_front.sv
// ----------------------------------------------------------------------------
// pafe_front
// Accepts input beats, expands each into its symbol slots, keeps the
// running FCS and frame type, and marks which symbols need escaping.
// ----------------------------------------------------------------------------
`default_nettype none

module pafe_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pafe_pkg::enc_in_t in_data,
  input  wire logic [31:0]       accm,
  input  wire logic              acf_compress,
  input  wire logic              pf_compress,
  output logic                   sym_valid,
  input  wire logic              sym_ready,
  output pafe_pkg::sym_t         sym_data
);

`include "assert_macros.svh"

  localparam int NS = pafe_pkg::SLOT_CNT;
  localparam int SW = pafe_pkg::SLOT_W;

  pafe_pkg::enc_in_t cur_r, cur_nxt;
  logic [NS-1:0]     pend_r, pend_nxt;
  logic              lcp_r, lcp_nxt;
  logic [15:0]       fcs_r, fcs_nxt;

  logic [NS-1:0]     sel_oh;
  logic [NS-1:0]     rest;
  pafe_pkg::slot_t   sel_idx;
  logic [7:0]        sym_byte;
  logic              is_raw;
  logic              is_covered;
  logic [31:0]       esc_map;
  logic              push;
  logic              accept;
  logic              lcp_new;
  logic              full_hdr;
  logic              two_proto;
  logic [NS-1:0]     new_mask;

  // Pick the earliest pending slot
  assign sel_oh = pend_r & (~pend_r + NS'(1));
  assign rest   = pend_r & ~sel_oh;

  always_comb begin
    sel_idx = pafe_pkg::SLOT_OPEN;
    for (int i = 0; i < NS; i++) begin
      if (sel_oh[i]) begin
        sel_idx = pafe_pkg::slot_t'(SW'(i));
      end
    end
  end

  // Byte of the selected slot
  always_comb begin
    case (sel_idx)
      pafe_pkg::SLOT_OPEN:  sym_byte = pafe_pkg::FLAG_BYTE;
      pafe_pkg::SLOT_ADDR:  sym_byte = pafe_pkg::ADDR_BYTE;
      pafe_pkg::SLOT_CTRL:  sym_byte = pafe_pkg::CTRL_BYTE;
      pafe_pkg::SLOT_PHI:   sym_byte = cur_r.protocol[15:8];
      pafe_pkg::SLOT_PLO:   sym_byte = cur_r.protocol[7:0];
      pafe_pkg::SLOT_DATA:  sym_byte = cur_r.data_byte;
      pafe_pkg::SLOT_FLO:   sym_byte = ~fcs_r[7:0];
      pafe_pkg::SLOT_FHI:   sym_byte = ~fcs_r[15:8];
      pafe_pkg::SLOT_CLOSE: sym_byte = pafe_pkg::FLAG_BYTE;
      default:              sym_byte = 8'h00;
    endcase
  end

  assign is_raw     = (sel_idx inside {pafe_pkg::SLOT_OPEN, pafe_pkg::SLOT_CLOSE});
  assign is_covered = (sel_idx inside {[pafe_pkg::SLOT_ADDR : pafe_pkg::SLOT_DATA]});

  // Escape decision: LCP frames escape every control character
  assign esc_map = lcp_r ? '1 : accm;

  assign sym_valid         = |pend_r;
  assign sym_data.sym_byte = sym_byte;
  assign sym_data.esc      = !is_raw &&
                             ((sym_byte == pafe_pkg::FLAG_BYTE) ||
                              (sym_byte == pafe_pkg::ESC_BYTE) ||
                              ((sym_byte[7:5] == 3'b000) && esc_map[sym_byte[4:0]]));
  assign sym_data.closing  = (sel_idx == pafe_pkg::SLOT_CLOSE);
  assign sym_data.last     = (rest == '0);

  assign push     = sym_valid && sym_ready;
  assign in_ready = (pend_r == '0) || (push && (rest == '0));
  assign accept   = in_valid && in_ready;

  // Classify the incoming beat into its slot mask
  assign lcp_new   = in_data.frame_start ? (in_data.protocol == pafe_pkg::LCP_PROTOCOL) : lcp_r;
  assign full_hdr  = !acf_compress || lcp_new;
  assign two_proto = !(pf_compress && (in_data.protocol[15:8] == 8'h00));

  always_comb begin
    new_mask                       = '0;
    new_mask[pafe_pkg::SLOT_OPEN]  = in_data.frame_start;
    new_mask[pafe_pkg::SLOT_ADDR]  = in_data.frame_start && full_hdr;
    new_mask[pafe_pkg::SLOT_CTRL]  = in_data.frame_start && full_hdr;
    new_mask[pafe_pkg::SLOT_PHI]   = in_data.frame_start && two_proto;
    new_mask[pafe_pkg::SLOT_PLO]   = in_data.frame_start;
    new_mask[pafe_pkg::SLOT_DATA]  = in_data.has_data;
    new_mask[pafe_pkg::SLOT_FLO]   = in_data.frame_end;
    new_mask[pafe_pkg::SLOT_FHI]   = in_data.frame_end;
    new_mask[pafe_pkg::SLOT_CLOSE] = in_data.frame_end;
  end

  // Next state: a frame start wins over any FCS update in flight
  always_comb begin
    cur_nxt  = accept ? in_data : cur_r;
    pend_nxt = accept ? new_mask : (push ? rest : pend_r);
    lcp_nxt  = (accept && in_data.frame_start) ?
               (in_data.protocol == pafe_pkg::LCP_PROTOCOL) : lcp_r;
    if (accept && in_data.frame_start) begin
      fcs_nxt = pafe_pkg::FCS_INIT;
    end else if (push && is_covered) begin
      fcs_nxt = pafe_pkg::fcs16_byte(fcs_r, sym_byte);
    end else if (push && sym_data.closing) begin
      fcs_nxt = pafe_pkg::FCS_INIT;
    end else begin
      fcs_nxt = fcs_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      lcp_r  <= 1'b0;
      fcs_r  <= pafe_pkg::FCS_INIT;
    end else begin
      pend_r <= pend_nxt;
      lcp_r  <= lcp_nxt;
      fcs_r  <= fcs_nxt;
    end
  end

  // Hold the current beat's payload
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  `PAFE_ASSERT(a_one_item_at_a_time, clk, rst_n, ($countones(pend_r) > 1) |-> !in_ready)
  `PAFE_ASSERT(a_close_ends_item, clk, rst_n, (push && sym_data.closing) |-> sym_data.last)
  `PAFE_ASSERT(a_start_resets_fcs, clk, rst_n, (accept && in_data.frame_start) |=> (pend_r[pafe_pkg::SLOT_OPEN] && (fcs_r == pafe_pkg::FCS_INIT)))

endmodule

`default_nettype wire

>>> hw/rtl/pafe_queue.sv
// ----------------------------------------------------------------------------
// pafe_queue
// Short symbol queue that decouples the front end from the escape stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pafe_queue #(
  parameter int DEPTH = pafe_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  wire pafe_pkg::sym_t wr_data,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output pafe_pkg::sym_t      rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pafe_pkg::sym_t  slots_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            push;
  logic            pop;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = slots_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed symbol
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pafe_back.sv
// ----------------------------------------------------------------------------
// pafe_back
// Pops symbols, splits escaped ones into 0x7D plus the flipped byte, and
// drives the registered output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module pafe_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  output logic                q_ready,
  input  wire pafe_pkg::sym_t q_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output pafe_pkg::enc_out_t  out_data
);

`include "assert_macros.svh"

  pafe_pkg::back_state_t state_r, state_nxt;
  logic                  out_valid_r;
  pafe_pkg::enc_out_t    out_r;
  pafe_pkg::sym_t        hold_r;
  logic                  load_en;
  logic                  pop;
  logic                  ld_valid;
  pafe_pkg::enc_out_t    ld_data;

  // Output register takes a new beat when empty or being drained
  assign load_en = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    if (load_en) begin
      case (state_r)
        pafe_pkg::BK_PASS: begin
          if (q_valid && q_data.esc) begin
            state_nxt = pafe_pkg::BK_ESC2;
          end
        end
        pafe_pkg::BK_ESC2: state_nxt = pafe_pkg::BK_PASS;
        default:           state_nxt = pafe_pkg::BK_PASS;
      endcase
    end
  end

  // Beat to load and queue pop
  always_comb begin
    pop      = 1'b0;
    ld_valid = 1'b0;
    ld_data  = out_r;
    case (state_r)
      pafe_pkg::BK_PASS: begin
        if (q_valid) begin
          pop      = load_en;
          ld_valid = 1'b1;
          if (q_data.esc) begin
            ld_data.out_byte     = pafe_pkg::ESC_BYTE;
            ld_data.last_of_run  = 1'b0;
            ld_data.closing_flag = 1'b0;
          end else begin
            ld_data.out_byte     = q_data.sym_byte;
            ld_data.last_of_run  = q_data.last;
            ld_data.closing_flag = q_data.closing;
          end
        end
      end
      pafe_pkg::BK_ESC2: begin
        ld_valid             = 1'b1;
        ld_data.out_byte     = hold_r.sym_byte ^ pafe_pkg::XOR_BYTE;
        ld_data.last_of_run  = hold_r.last;
        ld_data.closing_flag = 1'b0;
      end
      default: begin
        ld_valid = 1'b0;
      end
    endcase
  end

  assign q_ready   = pop;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pafe_pkg::BK_PASS;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_en) begin
        out_valid_r <= ld_valid;
      end
    end
  end

  // Hold output payload and the symbol being escaped
  always_ff @(posedge clk) begin
    if (load_en) begin
      out_r <= ld_data;
    end
    if (pop) begin
      hold_r <= q_data;
    end
  end

  `PAFE_ASSERT(a_esc_prefix_shown, clk, rst_n, (state_r == pafe_pkg::BK_ESC2) |-> (out_valid_r && (out_r.out_byte == pafe_pkg::ESC_BYTE) && !out_r.last_of_run))
  `PAFE_ASSERT(a_esc_second_byte, clk, rst_n, ((state_r == pafe_pkg::BK_ESC2) && load_en) |=> (out_r.out_byte == ($past(hold_r.sym_byte) ^ pafe_pkg::XOR_BYTE)))
  `PAFE_ASSERT(a_close_is_last_flag, clk, rst_n, (out_valid_r && out_r.closing_flag) |-> (out_r.last_of_run && (out_r.out_byte == pafe_pkg::FLAG_BYTE)))

endmodule

`default_nettype wire

>>> hw/rtl/ppp_async_frame_encoder.sv
// ----------------------------------------------------------------------------
// ppp_async_frame_encoder
// Async HDLC-like PPP framer: flags, header, byte stuffing and FCS-16.
//
//   Channel  Handshake              Beat
//   in_      in_valid / in_ready    enc_in_t: one payload byte plus flags
//   out_     out_valid / out_ready  enc_out_t: one encoded line byte
//   cfg_     cfg_valid / cfg_ready  cfg_index + cfg_wdata, always ready
//
// The front end turns one input beat into one symbol per cycle (0 to 9
// symbols) while the symbol queue has room; the back end sends one line byte
// per cycle while out_ready is high, and an escaped symbol gives two line bytes.
// Reset is synchronous; no clearing pass. A stalled output fills the
// symbol queue, after which in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_async_frame_encoder #(
  parameter int QUEUE_DEPTH = pafe_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire pafe_pkg::enc_in_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output pafe_pkg::enc_out_t                 out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pafe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_wdata
);

  logic [31:0]    accm_r;
  logic           acf_r;
  logic           pf_r;
  logic           fq_valid;
  logic           fq_ready;
  pafe_pkg::sym_t fq_data;
  logic           qb_valid;
  logic           qb_ready;
  pafe_pkg::sym_t qb_data;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accm_r <= '1;
      acf_r  <= 1'b0;
      pf_r   <= 1'b0;
    end else if (cfg_valid) begin
      case (pafe_pkg::cfg_reg_t'(cfg_index))
        pafe_pkg::CFG_ACCM: accm_r <= cfg_wdata;
        pafe_pkg::CFG_ACF:  acf_r  <= cfg_wdata[0];
        pafe_pkg::CFG_PF:   pf_r   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  pafe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .accm         (accm_r),
    .acf_compress (acf_r),
    .pf_compress  (pf_r),
    .sym_valid    (fq_valid),
    .sym_ready    (fq_ready),
    .sym_data     (fq_data)
  );

  pafe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  pafe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_data    (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
